[rtl/tac_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_pkg
// Shared types and constants of the thermistor code to temperature pipeline.
// ----------------------------------------------------------------------------
package tac_pkg;

	localparam int OHM_W  = 20;
	localparam int COEF_W = 40;
	localparam int T_W    = 64;
	localparam int QB     = 17;
	localparam int ADDR_W = 6;
	localparam int APB_W  = 64;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_SUM  = 2'd3;

	localparam logic [2:0] REG_SERIES = 3'd0;
	localparam logic [2:0] REG_REF    = 3'd1;
	localparam logic [2:0] REG_A      = 3'd2;
	localparam logic [2:0] REG_B      = 3'd3;
	localparam logic [2:0] REG_C      = 3'd4;
	localparam logic [2:0] REG_D      = 3'd5;

	localparam logic [23:0] LN2_Q24 = 24'd11629080;
	localparam logic signed [T_W-1:0] SAT_POS = 64'sh4000_0000_0000_0000;
	localparam logic signed [T_W-1:0] SAT_NEG = 64'shC000_0000_0000_0000;
	localparam logic [62:0] DIV_NUM = 63'h0006_4000_0000_0000;
	localparam logic signed [18:0] KELVIN_CENTI = 19'sd27315;
	localparam logic signed [18:0] TEMP_MAX = 19'sd32767;
	localparam logic signed [18:0] TEMP_MIN = -19'sd32768;

	typedef struct packed {
		logic [OHM_W-1:0]         series_ohms;
		logic [OHM_W-1:0]         reference_ohms;
		logic signed [COEF_W-1:0] coef_a;
		logic signed [COEF_W-1:0] coef_b;
		logic signed [COEF_W-1:0] coef_c;
		logic signed [COEF_W-1:0] coef_d;
	} cfg_t;

endpackage

[rtl/tac_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_regs
// Configuration register file behind the apb port.
// ----------------------------------------------------------------------------
module tac_regs import tac_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [APB_W-1:0]  pwdata,
	output logic [APB_W-1:0]  prdata,
	output cfg_t              cfg
);
	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign idx = paddr[5:3];
	assign wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.series_ohms    <= 20'd4700;
			cfg_q.reference_ohms <= 20'd4700;
			cfg_q.coef_a         <= 40'sd59004473468;
			cfg_q.coef_b         <= 40'sd4520057117;
			cfg_q.coef_c         <= 40'sd46202552;
			cfg_q.coef_d         <= 40'sd1187962;
		end else if (wr) begin
			case (idx)
				REG_SERIES: cfg_q.series_ohms    <= pwdata[OHM_W-1:0];
				REG_REF:    cfg_q.reference_ohms <= pwdata[OHM_W-1:0];
				REG_A:      cfg_q.coef_a         <= pwdata[COEF_W-1:0];
				REG_B:      cfg_q.coef_b         <= pwdata[COEF_W-1:0];
				REG_C:      cfg_q.coef_c         <= pwdata[COEF_W-1:0];
				REG_D:      cfg_q.coef_d         <= pwdata[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SERIES: prdata = APB_W'(cfg_q.series_ohms);
			REG_REF:    prdata = APB_W'(cfg_q.reference_ohms);
			REG_A:      prdata = APB_W'(unsigned'(cfg_q.coef_a));
			REG_B:      prdata = APB_W'(unsigned'(cfg_q.coef_b));
			REG_C:      prdata = APB_W'(unsigned'(cfg_q.coef_c));
			REG_D:      prdata = APB_W'(unsigned'(cfg_q.coef_d));
			default:    prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

[rtl/tac_log.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_log
// Divider ratio, status check and natural log of the ratio, one bit a stage.
// ----------------------------------------------------------------------------
module tac_log import tac_pkg::*; #(
	parameter int ADC_BITS = 10,
	parameter int F = 20,
	localparam int NUM_W = OHM_W + ADC_BITS,
	localparam int EW = $clog2(NUM_W),
	localparam int DW = EW + F + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 vld_i,
	input  logic [ADC_BITS-1:0]  code_i,
	input  logic [OHM_W-1:0]     series_i,
	input  logic [OHM_W-1:0]     ref_i,
	output logic                 vld_o,
	output logic [1:0]           st_o,
	output logic signed [DW-1:0] u_o
);
	localparam logic [ADC_BITS-1:0] FS_V = {ADC_BITS{1'b1}};

	logic             vld_s1, vld_s2;
	logic [1:0]       st_s1, st_s2;
	logic [NUM_W-1:0] v_s1 [2];
	logic [1:0]       st_c;
	logic             vld_si [0:F];
	logic [1:0]       st_si [0:F];
	logic [EW+F-1:0]  lg [2];
	logic             vld_s4, vld_s5;
	logic [1:0]       st_s4, st_s5;
	logic signed [DW-1:0]    diff_s4;
	logic signed [DW-1:0]    u_s5;
	logic signed [DW+24:0]   prod;

	always_comb begin
		if (code_i == '0 || series_i == '0)
			st_c = ST_ZERO;
		else if (code_i == FS_V || ref_i == '0)
			st_c = ST_FULL;
		else
			st_c = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		st_s1   <= st_c;
		v_s1[0] <= NUM_W'(series_i) * NUM_W'(code_i);
		v_s1[1] <= NUM_W'(ref_i) * NUM_W'(FS_V - code_i);
		st_s2   <= st_s1;
	end

	for (genvar ln = 0; ln < 2; ln++) begin : g_lane
		logic [EW-1:0]    e_c, e_s2;
		logic [NUM_W-1:0] v_s2;
		logic [NUM_W+31:0] w;
		logic [31:0]      m_si [0:F];
		logic [F-1:0]     f_si [0:F];
		logic [EW-1:0]    e_si [0:F];

		// index of the top set bit
		always_comb begin
			e_c = '0;
			for (int i = 0; i < NUM_W; i++) begin
				if (v_s1[ln][i])
					e_c = EW'(i);
			end
		end

		always_ff @(posedge clk) begin
			e_s2 <= e_c;
			v_s2 <= v_s1[ln];
		end

		// mantissa normalized to q1.31, low bits truncated
		assign w = {v_s2, 32'd0} << (EW'(NUM_W - 1) - e_s2);

		always_ff @(posedge clk) begin
			m_si[0] <= w[NUM_W+31 -: 32];
			f_si[0] <= '0;
			e_si[0] <= e_s2;
		end

		for (genvar k = 0; k < F; k++) begin : g_it
			logic [63:0] sq;
			logic [32:0] sh;
			assign sq = 64'(m_si[k]) * 64'(m_si[k]);
			assign sh = sq[63:31];
			always_ff @(posedge clk) begin
				if (sh[32]) begin
					m_si[k+1] <= sh[32:1];
					f_si[k+1] <= {f_si[k][F-2:0], 1'b1};
				end else begin
					m_si[k+1] <= sh[31:0];
					f_si[k+1] <= {f_si[k][F-2:0], 1'b0};
				end
				e_si[k+1] <= e_si[k];
			end
		end

		assign lg[ln] = {e_si[F], f_si[F]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_si[0] <= 1'b0;
		else
			vld_si[0] <= vld_s2;
	end

	always_ff @(posedge clk) begin
		st_si[0] <= st_s2;
	end

	for (genvar k = 0; k < F; k++) begin : g_ctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_si[k+1] <= 1'b0;
			else
				vld_si[k+1] <= vld_si[k];
		end
		always_ff @(posedge clk) begin
			st_si[k+1] <= st_si[k];
		end
	end

	assign prod = (DW + 25)'(diff_s4) * (DW + 25)'($signed({1'b0, LN2_Q24}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s4 <= vld_si[F];
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		st_s4   <= st_si[F];
		diff_s4 <= $signed({1'b0, lg[0]}) - $signed({1'b0, lg[1]});
		st_s5   <= st_s4;
		// arithmetic shift is the floor
		u_s5    <= prod[DW+23:24];
	end

	assign vld_o = vld_s5;
	assign st_o  = st_s5;
	assign u_o   = u_s5;

endmodule

[rtl/tac_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_mac
// One horner step: t_o = clamp(coef + floor(t_i * u / 2^F)), five stages.
// ----------------------------------------------------------------------------
module tac_mac import tac_pkg::*; #(
	parameter int UW = 26,
	parameter int F = 20
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     vld_i,
	input  logic [1:0]               st_i,
	input  logic signed [UW-1:0]     u_i,
	input  logic signed [T_W-1:0]    t_i,
	input  logic signed [COEF_W-1:0] coef,
	output logic                     vld_o,
	output logic [1:0]               st_o,
	output logic signed [UW-1:0]     u_o,
	output logic signed [T_W-1:0]    t_o
);
	localparam int PW  = 63 + UW;
	localparam int RW2 = PW - F;
	localparam logic [RW2:0] R_SAT = (RW2 + 1)'(64'h4000_0000_0000_0000);
	localparam logic signed [64:0] LIM_P = 65'sh0_4000_0000_0000_0000;
	localparam logic signed [64:0] LIM_N = 65'sh1_C000_0000_0000_0000;

	logic [4:0]          vld_q;
	logic [1:0]          st_s1, st_s2, st_s3, st_s4, st_s5;
	logic signed [UW-1:0] u_s1, u_s2, u_s3, u_s4, u_s5;
	logic                neg_s1, neg_s2, neg_s3, neg_s4;
	logic [62:0]         mt_s1;
	logic [UW-1:0]       mu_s1;
	logic [31+UW:0]      lo_s2;
	logic [30+UW:0]      hi_s2;
	logic [PW-1:0]       p;
	logic [RW2-1:0]      r_s3;
	logic                rest_s3;
	logic [RW2:0]        r2;
	logic [62:0]         mag_s4;
	logic signed [64:0]  c65, m65, sv;
	logic signed [T_W-1:0] t_s5;
	logic signed [T_W-1:0] tneg;
	logic signed [UW-1:0]  uneg;

	assign tneg = -t_i;
	assign uneg = -u_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else
			vld_q <= {vld_q[3:0], vld_i};
	end

	always_ff @(posedge clk) begin
		st_s1  <= st_i;
		u_s1   <= u_i;
		neg_s1 <= t_i[T_W-1] ^ u_i[UW-1];
		mt_s1  <= t_i[T_W-1] ? tneg[62:0] : t_i[62:0];
		mu_s1  <= u_i[UW-1] ? unsigned'(uneg) : unsigned'(u_i);

		st_s2  <= st_s1;
		u_s2   <= u_s1;
		neg_s2 <= neg_s1;
		lo_s2  <= (32 + UW)'(mt_s1[31:0]) * (32 + UW)'(mu_s1);
		hi_s2  <= (31 + UW)'(mt_s1[62:32]) * (31 + UW)'(mu_s1);

		st_s3   <= st_s2;
		u_s3    <= u_s2;
		neg_s3  <= neg_s2;
		r_s3    <= p[PW-1:F];
		rest_s3 <= |p[F-1:0];

		st_s4  <= st_s3;
		u_s4   <= u_s3;
		neg_s4 <= neg_s3;
		mag_s4 <= (r2 > R_SAT) ? 63'h4000_0000_0000_0000 : r2[62:0];

		st_s5 <= st_s4;
		u_s5  <= u_s4;
		t_s5  <= (sv > LIM_P) ? SAT_POS : ((sv < LIM_N) ? SAT_NEG : sv[T_W-1:0]);
	end

	assign p  = {hi_s2, 32'd0} + PW'(lo_s2);
	// rounding toward minus infinity for a negative product
	assign r2 = {1'b0, r_s3} + (RW2 + 1)'(neg_s3 & rest_s3);

	assign c65 = {{(65 - COEF_W){coef[COEF_W-1]}}, coef};
	assign m65 = $signed({2'b00, mag_s4});
	assign sv  = neg_s4 ? (c65 - m65) : (c65 + m65);

	assign vld_o = vld_q[4];
	assign st_o  = st_s5;
	assign u_o   = u_s5;
	assign t_o   = t_s5;

endmodule

[rtl/tac_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_div
// Reciprocal of the sum by restoring division, one quotient bit a stage,
// then kelvin offset and 16 bit saturation.
// ----------------------------------------------------------------------------
module tac_div import tac_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  vld_i,
	input  logic [1:0]            st_i,
	input  logic signed [T_W-1:0] t_i,
	output logic                  done,
	output logic signed [15:0]    temp_centi_c,
	output logic [1:0]            status
);
	localparam int RW = 63 + QB;

	logic          vld_s0, vld_s1;
	logic [1:0]    st_s0, st_s1;
	logic [62:0]   s_s0, dvd_s0;
	logic [1:0]    st_c;
	logic          vld_sq [0:QB];
	logic [1:0]    st_sq [0:QB];
	logic          ovf_sq [0:QB];
	logic [62:0]   s_sq [0:QB];
	logic [RW-1:0] rem_sq [0:QB];
	logic [QB-1:0] q_sq [0:QB];
	logic signed [18:0] tmp;
	logic signed [15:0] temp_q;
	logic [1:0]    status_q;
	logic          done_q;

	always_comb begin
		if (st_i == ST_OK && (t_i[T_W-1] || t_i == '0))
			st_c = ST_SUM;
		else
			st_c = st_i;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s0 <= vld_i;
			vld_s1 <= vld_s0;
		end
	end

	always_ff @(posedge clk) begin
		st_s0  <= st_c;
		s_s0   <= t_i[62:0];
		dvd_s0 <= DIV_NUM + {1'b0, t_i[62:1]};
		st_s1  <= st_s0;
	end

	assign vld_sq[0] = vld_s1;
	assign st_sq[0]  = st_s1;

	// quotient too large for the output range
	always_ff @(posedge clk) begin
		ovf_sq[0] <= RW'(dvd_s0) >= {s_s0, {QB{1'b0}}};
		s_sq[0]   <= s_s0;
		rem_sq[0] <= RW'(dvd_s0);
		q_sq[0]   <= '0;
	end

	for (genvar j = 0; j < QB; j++) begin : g_bit
		logic [RW-1:0] sh;
		logic          ge;
		assign sh = RW'(s_sq[j]) << (QB - 1 - j);
		assign ge = rem_sq[j] >= sh;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_sq[j+1] <= 1'b0;
			else
				vld_sq[j+1] <= vld_sq[j];
		end
		always_ff @(posedge clk) begin
			st_sq[j+1]  <= st_sq[j];
			ovf_sq[j+1] <= ovf_sq[j];
			s_sq[j+1]   <= s_sq[j];
			rem_sq[j+1] <= ge ? rem_sq[j] - sh : rem_sq[j];
			q_sq[j+1]   <= {q_sq[j][QB-2:0], ge};
		end
	end

	assign tmp = $signed({2'b00, q_sq[QB]}) - KELVIN_CENTI;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= vld_sq[QB];
	end

	always_ff @(posedge clk) begin
		status_q <= st_sq[QB];
		if (st_sq[QB] != ST_OK)
			temp_q <= '0;
		else if (ovf_sq[QB] || tmp > TEMP_MAX)
			temp_q <= 16'sh7FFF;
		else if (tmp < TEMP_MIN)
			temp_q <= 16'sh8000;
		else
			temp_q <= tmp[15:0];
	end

	assign done         = done_q;
	assign temp_centi_c = temp_q;
	assign status       = status_q;

endmodule

[rtl/thermistor_adc_to_celsius_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermistor_adc_to_celsius_core
// Converter code of a thermistor divider to temperature in 0.01 C.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+----------------------------
//  sample   | in        | start, busy            | adc_code
//  result   | out       | done (one-cycle strobe)| temp_centi_c, status
//  config   | in/out    | apb, pready always high| paddr, pwdata, prdata
//
//  one item is taken every cycle; busy is always low
//  the pipeline is the LOG_FRAC_BITS + 5 stage log, three five-stage
//  horner steps and the 20 stage divider
//  reset clears the valid bits; items in flight at reset are dropped
//  the result strobe cannot be held off, nothing in the pipeline stalls
// ----------------------------------------------------------------------------
module thermistor_adc_to_celsius_core import tac_pkg::*; #(
	parameter int ADC_BITS = 10,
	parameter int LOG_FRAC_BITS = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [ADC_BITS-1:0] adc_code,
	output logic                done,
	output logic signed [15:0]  temp_centi_c,
	output logic [1:0]          status,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [APB_W-1:0]    pwdata,
	output logic [APB_W-1:0]    prdata,
	output logic                pready
);
	localparam int NUM_W = OHM_W + ADC_BITS;
	localparam int EW = $clog2(NUM_W);
	localparam int DW = EW + LOG_FRAC_BITS + 1;

	cfg_t cfg;
	logic vld_l, vld_m1, vld_m2, vld_m3;
	logic [1:0] st_l, st_m1, st_m2, st_m3;
	logic signed [DW-1:0] u_l, u_m1, u_m2, u_m3;
	logic signed [T_W-1:0] t_d, t_m1, t_m2, t_m3;

	assign busy   = 1'b0;
	assign pready = 1'b1;

	tac_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
	);

	tac_log #(.ADC_BITS(ADC_BITS), .F(LOG_FRAC_BITS)) u_log (
		.clk, .arst_n,
		.vld_i(start & ~busy), .code_i(adc_code),
		.series_i(cfg.series_ohms), .ref_i(cfg.reference_ohms),
		.vld_o(vld_l), .st_o(st_l), .u_o(u_l)
	);

	assign t_d = T_W'(cfg.coef_d);

	tac_mac #(.UW(DW), .F(LOG_FRAC_BITS)) u_mac_c (
		.clk, .arst_n, .vld_i(vld_l), .st_i(st_l), .u_i(u_l), .t_i(t_d),
		.coef(cfg.coef_c), .vld_o(vld_m1), .st_o(st_m1), .u_o(u_m1), .t_o(t_m1)
	);

	tac_mac #(.UW(DW), .F(LOG_FRAC_BITS)) u_mac_b (
		.clk, .arst_n, .vld_i(vld_m1), .st_i(st_m1), .u_i(u_m1), .t_i(t_m1),
		.coef(cfg.coef_b), .vld_o(vld_m2), .st_o(st_m2), .u_o(u_m2), .t_o(t_m2)
	);

	tac_mac #(.UW(DW), .F(LOG_FRAC_BITS)) u_mac_a (
		.clk, .arst_n, .vld_i(vld_m2), .st_i(st_m2), .u_i(u_m2), .t_i(t_m2),
		.coef(cfg.coef_a), .vld_o(vld_m3), .st_o(st_m3), .u_o(u_m3), .t_o(t_m3)
	);

	tac_div u_div (
		.clk, .arst_n, .vld_i(vld_m3), .st_i(st_m3), .t_i(t_m3),
		.done, .temp_centi_c, .status
	);

	// the log term is not needed past the last horner step
	logic unused_u;
	assign unused_u = ^u_m3;

endmodule

[rtl/tac_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_checker
// Port level checks of the conversion pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module tac_checker import tac_pkg::*; #(
	parameter int LAT = 60
) (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic signed [15:0] temp_centi_c,
	input logic [1:0]        status
);
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> temp_centi_c == 16'sd0)
		else $error("error result with nonzero temperature");

	a_item_out: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("item lost in pipeline");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without item");

endmodule

bind thermistor_adc_to_celsius_core tac_checker #(.LAT(LOG_FRAC_BITS + 40)) u_tac_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.temp_centi_c(temp_centi_c), .status(status)
);
